// ===== rtl/packed_to_planar_tile_converter_core_defines.svh =====
// Assertion macros for the converter's checker file.
`ifndef PACKED_TO_PLANAR_TILE_CONVERTER_CORE_DEFINES_SVH
`define PACKED_TO_PLANAR_TILE_CONVERTER_CORE_DEFINES_SVH

// Concurrent assertion, disabled while reset is high
`define P2PT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Concurrent assertion that also holds across reset
`define P2PT_ASSERT_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/p2pt_pkg.sv =====
// Package: types, codes, microcode table and pixel functions of the tile converter.
`default_nettype none

package p2pt_pkg;

  localparam int ROW_W     = 64;
  localparam int TILE_ROWS = 8;

  // Source depth codes
  localparam logic [1:0] DEPTH_1 = 2'd0;
  localparam logic [1:0] DEPTH_2 = 2'd1;
  localparam logic [1:0] DEPTH_4 = 2'd2;
  localparam logic [1:0] DEPTH_8 = 2'd3;

  // Target mode codes
  localparam logic [1:0] MODE_2P     = 2'd0;
  localparam logic [1:0] MODE_4P     = 2'd1;
  localparam logic [1:0] MODE_8P     = 2'd2;
  localparam logic [1:0] MODE_LINEAR = 2'd3;

  // Register indexes
  localparam logic REG_SOURCE_DEPTH = 1'b0;
  localparam logic REG_TARGET_MODE  = 1'b1;

  localparam logic [1:0] SOURCE_DEPTH_RESET = DEPTH_8;
  localparam logic [1:0] TARGET_MODE_RESET  = MODE_4P;

  // Pixel masks per depth
  localparam logic [7:0] MASK_1 = 8'b00000001;
  localparam logic [7:0] MASK_2 = 8'b00000011;
  localparam logic [7:0] MASK_4 = 8'b00001111;
  localparam logic [7:0] MASK_8 = 8'b11111111;

  typedef enum logic [1:0] {
    STEP_FETCH,
    STEP_LIN,
    STEP_PLO,
    STEP_PHI
  } step_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PIXEL,
    EMIT_PLANE
  } emit_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_LINEAR,
    COND_IDX_END,
    COND_TILE_END
  } cond_t;

  // One microcode word
  typedef struct packed {
    logic  take_in;
    emit_t emit;
    logic  plane_hi;
    logic  idx_inc;
    logic  pair_inc;
    logic  clr;
    logic  mark_last;
    cond_t cond;
    logic  alt_if_full;
    step_t jmp;
    step_t alt;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic linear;
    logic tile_full;
    logic idx_end;
    logic pair_last;
  } stat_t;

  // Control handed to the datapath
  typedef struct packed {
    logic  fire;
    logic  take_in;
    emit_t emit;
    logic  plane_hi;
    logic  idx_inc;
    logic  pair_inc;
    logic  clr;
    logic  last;
  } ctl_t;

  // Microcode program
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      STEP_FETCH: begin
        w.take_in     = 1'b1;
        w.emit        = EMIT_NONE;
        w.clr         = 1'b1;
        w.cond        = COND_LINEAR;
        w.alt_if_full = 1'b1;
        w.jmp         = STEP_LIN;
        w.alt         = STEP_PLO;
      end
      STEP_LIN: begin
        w.emit      = EMIT_PIXEL;
        w.idx_inc   = 1'b1;
        w.mark_last = 1'b1;
        w.cond      = COND_IDX_END;
        w.jmp       = STEP_FETCH;
        w.alt       = STEP_LIN;
      end
      STEP_PLO: begin
        w.emit = EMIT_PLANE;
        w.cond = COND_ALWAYS;
        w.jmp  = STEP_PHI;
        w.alt  = STEP_PHI;
      end
      STEP_PHI: begin
        w.emit      = EMIT_PLANE;
        w.plane_hi  = 1'b1;
        w.idx_inc   = 1'b1;
        w.pair_inc  = 1'b1;
        w.mark_last = 1'b1;
        w.cond      = COND_TILE_END;
        w.jmp       = STEP_FETCH;
        w.alt       = STEP_PLO;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] depth_mask(logic [1:0] depth);
    logic [7:0] m;
    unique case (depth)
      DEPTH_1: m = MASK_1;
      DEPTH_2: m = MASK_2;
      DEPTH_4: m = MASK_4;
      default: m = MASK_8;
    endcase
    return m;
  endfunction

  // Pixel p (0 = leftmost) of a packed row, masked to the source depth
  function automatic logic [7:0] pixel_of(logic [ROW_W-1:0] row, logic [1:0] depth,
                                          logic [2:0] p);
    logic [7:0] b;
    logic [7:0] v;
    unique case (depth)
      DEPTH_1: begin
        b = row[7:0];
        v = b >> (3'd7 - p);
      end
      DEPTH_2: begin
        b = p[2] ? row[15:8] : row[7:0];
        v = b >> {~p[1:0], 1'b0};
      end
      DEPTH_4: begin
        b = row[{p[2:1], 3'b000} +: 8];
        v = b >> {~p[0], 2'b00};
      end
      default: begin
        b = row[{p, 3'b000} +: 8];
        v = b;
      end
    endcase
    return v & depth_mask(depth);
  endfunction

  // Bit-plane byte of one row, leftmost pixel in bit 7
  function automatic logic [7:0] plane_byte(logic [ROW_W-1:0] row, logic [1:0] depth,
                                            logic [2:0] plane);
    logic [7:0] acc;
    logic [7:0] pix;
    acc = '0;
    for (int p = 0; p < 8; p++) begin
      pix = pixel_of(row, depth, 3'(p));
      acc[3'(7 - p)] = pix[plane];
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/packed_to_planar_tile_converter_core.sv =====
// Top level: packed-to-planar tile converter with stream ports and APB registers.
`default_nettype none

// Converts 8x8 tiles of packed pixels (1, 2, 4 or 8 bits) to bit-plane bytes
// or to one byte per pixel. Each s_tdata transaction carries one tile row.
// In linear mode a row yields eight bytes: the row is accepted, then one
// output byte follows per cycle unless the output stalls. In planar modes
// rows one to seven are written to the row store; the eighth row starts a
// readout of 16, 32 or 64 bytes as the tile is read out in plane pairs, row
// by row, the lower plane first. The output rate of one byte per cycle, when
// the output does not stall, is set by the microcode sequencer, which steps
// once per byte into a single output register; the next row is accepted
// while the final byte still waits there. m_tlast marks the final byte
// caused by a row. Registers (APB, 32-bit): 0x0 source_depth (0=1,1=2,2=4,
// 3=8 bpp, reset 3), 0x4 target_mode (0=2,1=4,2=8 planes,3=linear, reset 1).
// Write registers only while idle. No clearing pass follows reset.
module packed_to_planar_tile_converter_core (
  input  logic        clk,
  input  logic        rst,
  // Input rows
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] row_data
  // Output bytes
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import p2pt_pkg::*;

  logic [1:0]       source_depth;
  logic [1:0]       target_mode;
  logic [ROW_W-1:0] row_store [TILE_ROWS];
  logic [2:0]       row_count;
  logic [ROW_W-1:0] held_row;
  logic [2:0]       idx;
  logic [1:0]       pair;
  logic             out_valid;
  logic [7:0]       out_data;
  logic             out_last;

  stat_t      stat;
  ctl_t       ctl;
  logic       in_fire;
  logic       emit_fire;
  logic       linear;
  logic       pair_last;
  logic [7:0] byte_next;

  assign pready = 1'b1;
  assign linear = (target_mode == MODE_LINEAR);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      source_depth <= SOURCE_DEPTH_RESET;
      target_mode  <= TARGET_MODE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SOURCE_DEPTH: source_depth <= pwdata[1:0];
        REG_TARGET_MODE:  target_mode  <= pwdata[1:0];
        default:          ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_DEPTH: prdata = {30'd0, source_depth};
      REG_TARGET_MODE:  prdata = {30'd0, target_mode};
      default:          prdata = '0;
    endcase
  end

  // Last plane pair of the tile for the current mode
  always_comb begin
    unique case (target_mode)
      MODE_2P: pair_last = 1'b1;
      MODE_4P: pair_last = (pair == 2'd1);
      MODE_8P: pair_last = (pair == 2'd3);
      default: pair_last = 1'b1;
    endcase
  end

  // Sequencer status
  always_comb begin
    stat.in_valid  = s_tvalid;
    stat.out_free  = !out_valid || m_tready;
    stat.linear    = linear;
    stat.tile_full = (row_count == 3'd7);
    stat.idx_end   = (idx == 3'd7);
    stat.pair_last = pair_last;
  end

  p2pt_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  assign s_tready  = ctl.take_in;
  assign in_fire   = ctl.fire && ctl.take_in;
  assign emit_fire = ctl.fire && (ctl.emit != EMIT_NONE);

  // Byte selection: linear pixel or plane byte of the indexed row
  always_comb begin
    if (ctl.emit == EMIT_PIXEL) begin
      byte_next = pixel_of(held_row, source_depth, idx);
    end else begin
      byte_next = plane_byte(row_store[idx], source_depth, {pair, ctl.plane_hi});
    end
  end

  // Row capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (linear) begin
        held_row <= s_tdata;
      end else begin
        row_store[row_count] <= s_tdata;
      end
    end
  end

  // Row counter and byte counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      idx       <= '0;
      pair      <= '0;
    end else begin
      if (in_fire && !linear) begin
        row_count <= row_count + 3'd1;
      end
      if (ctl.fire && ctl.clr) begin
        idx  <= '0;
        pair <= '0;
      end else if (emit_fire) begin
        if (ctl.idx_inc) begin
          idx <= idx + 3'd1;
        end
        if (ctl.pair_inc && (idx == 3'd7)) begin
          pair <= pair + 2'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data <= byte_next;
      out_last <= ctl.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ===== rtl/p2pt_seq.sv =====
// Microcode sequencer: step register, control ROM and conditional jumps.
`default_nettype none

module p2pt_seq (
  input  logic            clk,
  input  logic            rst,
  input  p2pt_pkg::stat_t stat,
  output p2pt_pkg::ctl_t  ctl
);
  import p2pt_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t uw;
  logic   go;
  logic   cond_true;

  // Step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // Decode current word, evaluate condition, pick next step
  always_comb begin
    uw = ucode_rom(step);
    go = uw.take_in ? stat.in_valid : stat.out_free;

    unique case (uw.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_LINEAR:   cond_true = stat.linear;
      COND_IDX_END:  cond_true = stat.idx_end;
      COND_TILE_END: cond_true = stat.idx_end & stat.pair_last;
      default:       cond_true = 1'b0;
    endcase

    step_next = step;
    if (go) begin
      if (cond_true) begin
        step_next = uw.jmp;
      end else if (!uw.alt_if_full || stat.tile_full) begin
        step_next = uw.alt;
      end
    end

    ctl.fire     = go;
    ctl.take_in  = uw.take_in;
    ctl.emit     = uw.emit;
    ctl.plane_hi = uw.plane_hi;
    ctl.idx_inc  = uw.idx_inc;
    ctl.pair_inc = uw.pair_inc;
    ctl.clr      = uw.clr;
    ctl.last     = uw.mark_last & cond_true;
  end

endmodule

`default_nettype wire

// ===== rtl/p2pt_checker.sv =====
// Port-level checker for the tile converter, bound to the top level.
`default_nettype none
`include "packed_to_planar_tile_converter_core_defines.svh"

module p2pt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [63:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // Stalled output byte holds
  `P2PT_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

  // Reset empties the output register
  `P2PT_ASSERT_NR(a_rst_empty, clk, rst |=> !m_tvalid, "output valid after reset")

  // No new row is taken while a burst is still being emitted
  `P2PT_ASSERT(a_no_take_mid_burst, clk, rst, m_tvalid && !m_tlast |-> !s_tready, "row accepted in mid burst")

  // A source_depth write reads back on the next cycle
  `P2PT_ASSERT(a_depth_readback, clk, rst, psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || (prdata[1:0] == $past(pwdata[1:0])), "source_depth readback mismatch")

endmodule

bind packed_to_planar_tile_converter_core p2pt_checker u_p2pt_checker (.*);

`default_nettype wire

// ===== tb/packed_to_planar_tile_converter_core_tb.sv =====
// Self-checking testbench for the packed-to-planar tile converter core.
`timescale 1ns / 1ps

module packed_to_planar_tile_converter_core_tb;
  import p2pt_pkg::*;

  localparam int DRAIN_CYCLES = 80;       // longest tile readout plus margin
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ROWS  = 300;

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Converter state mirrored by the predictor
  logic [63:0] tile_rows [TILE_ROWS];
  logic [2:0]  row_idx = '0;
  logic [1:0]  cur_depth = SOURCE_DEPTH_RESET;
  logic [1:0]  cur_mode = TARGET_MODE_RESET;

  out_beat_t   expected_beats [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;

  packed_to_planar_tile_converter_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packed_to_planar_tile_converter_core_tb: done, errors");
      $finish;
    end
  end

  // Output backpressure
  always @(negedge clk) begin
    m_tready = no_idle || ($urandom_range(0, 99) >= 30);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Pixel p of a packed row, leftmost pixel in the high bits of its byte
  function automatic logic [7:0] pick_pixel(logic [63:0] row, logic [1:0] depth,
                                            int unsigned p);
    int unsigned bpp;
    int unsigned bitpos;
    int unsigned shift;
    logic [7:0]  b;
    logic [7:0]  mask;
    bpp    = 1 << depth;
    bitpos = p * bpp;
    b      = 8'(row >> (8 * (bitpos / 8)));
    shift  = 8 - bpp - (bitpos % 8);
    mask   = 8'((1 << bpp) - 1);
    return (b >> shift) & mask;
  endfunction

  // One bit plane of a row, leftmost pixel in bit 7; zero above the depth
  function automatic logic [7:0] plane_bits(logic [63:0] row, logic [1:0] depth,
                                            int unsigned plane);
    logic [7:0] acc;
    logic [7:0] pix;
    acc = '0;
    if (plane >= (1 << depth)) return acc;
    for (int unsigned p = 0; p < 8; p++) begin
      pix = pick_pixel(row, depth, p);
      acc = {acc[6:0], pix[plane]};
    end
    return acc;
  endfunction

  // Expected bytes for one accepted row
  task automatic convert_row(input logic [63:0] row);
    int unsigned planes;
    if (cur_mode == MODE_LINEAR) begin
      for (int unsigned p = 0; p < 8; p++)
        expected_beats.push_back({pick_pixel(row, cur_depth, p), p == 7});
    end else begin
      tile_rows[row_idx] = row;
      if (row_idx != 3'd7) begin
        row_idx++;
      end else begin
        row_idx = '0;
        planes  = 2 << cur_mode;
        for (int unsigned pair = 0; pair < planes; pair += 2) begin
          for (int unsigned r = 0; r < TILE_ROWS; r++) begin
            expected_beats.push_back({plane_bits(tile_rows[r], cur_depth, pair), 1'b0});
            expected_beats.push_back({plane_bits(tile_rows[r], cur_depth, pair + 1),
                                      (pair == planes - 2) && (r == TILE_ROWS - 1)});
          end
        end
      end
    end
  endtask

  // Output checker
  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_tdata));
      end else begin
        exp_beat = expected_beats.pop_front();
        if (m_tdata !== exp_beat.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, exp_beat.data));
        if (m_tlast !== exp_beat.last)
          report_mismatch($sformatf("last %0b, want %0b", m_tlast, exp_beat.last));
      end
    end
  end

  // Send one row; valid stays high for a following row unless an idle gap is drawn
  task automatic send_row(input logic [63:0] row);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tdata  = row;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    convert_row(row);
  endtask

  // Hold the input off until every expected byte has arrived
  task automatic drain_outputs();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    drain_outputs();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register
  task automatic write_reg(input logic idx, input logic [1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {30'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_SOURCE_DEPTH) cur_depth = value;
    else cur_mode = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[1:0] !== value)
      report_mismatch($sformatf("reg %0d reads %0h, want %0h", idx, prdata[1:0], value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Registers are written only once the converter has gone quiet
  task automatic set_config(input logic [1:0] depth, input logic [1:0] mode);
    drain_outputs();
    write_reg(REG_SOURCE_DEPTH, depth);
    write_reg(REG_TARGET_MODE, mode);
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] row;
    row = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: row = '0;
      1: row = '1;
      default: ;
    endcase
    return row;
  endfunction

  // Reset settings: 8-bit source into 4 planes drops the upper source bits
  task automatic test_reset_tile();
    send_row('0);
    send_row('1);
    send_row(64'h0123_4567_89ab_cdef);
    send_row(64'haaaa_aaaa_aaaa_aaaa);
    send_row(64'h5555_5555_5555_5555);
    send_row(64'h8000_0000_0000_0001);
    send_row(64'hf0f0_0f0f_ff00_00ff);
    send_row(64'hfedc_ba98_7654_3210);
    wait_idle();
  endtask

  // Linear mode at every source depth, high row bytes carrying junk
  task automatic test_linear_depths();
    for (int d = 0; d < 4; d++) begin
      set_config(2'(d), MODE_LINEAR);
      send_row(64'hdead_beef_c3a5_5ac3);
    end
    send_row('1);
    wait_idle();
  endtask

  // Registers change in mid-tile; the settings at the eighth row decide the readout
  task automatic test_mid_tile_write();
    set_config(DEPTH_8, MODE_2P);
    send_row(64'h1122_3344_5566_7788);
    send_row(64'h0f1e_2d3c_4b5a_6978);
    send_row('1);
    wait_idle();
    // 1-bit source into 8 planes: upper planes are zero filler
    set_config(DEPTH_1, MODE_8P);
    send_row(64'hffff_ffff_ffff_ff81);
    send_row(64'h0000_0000_0000_0042);
    send_row(64'h0000_0000_0000_00ff);
    send_row('0);
    send_row(64'h0000_0000_0000_00a5);
    wait_idle();
  endtask

  // Random rows over a series of settings
  task automatic test_random_rows();
    int         sent;
    int         phase;
    int         rows;
    logic [1:0] depth;
    logic [1:0] mode;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ROWS) begin
      case (phase)
        0: begin depth = DEPTH_1; mode = MODE_2P;     end
        1: begin depth = DEPTH_8; mode = MODE_LINEAR; end
        2: begin depth = DEPTH_8; mode = MODE_8P;     end
        3: begin depth = DEPTH_2; mode = MODE_4P;     end
        default: begin
          depth = 2'($urandom_range(0, 3));
          mode  = 2'($urandom_range(0, 3));
        end
      endcase
      set_config(depth, mode);
      no_idle = (phase == 2);
      rows = $urandom_range(8, 40);
      for (int i = 0; i < rows; i++) begin
        // one hold-off until the output has fully drained
        if (phase == 4 && i == rows / 2) drain_outputs();
        send_row(rand_row());
        sent++;
      end
      wait_idle();
      no_idle = 1'b0;
      phase++;
    end
  endtask

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_tile();
    test_linear_depths();
    test_mid_tile_write();
    test_random_rows();
    wait_idle();
    if (mismatches == 0) begin
      $display("packed_to_planar_tile_converter_core_tb: done, clean");
    end else begin
      $display("packed_to_planar_tile_converter_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/p2pt_pkg.sv
rtl/p2pt_seq.sv
rtl/packed_to_planar_tile_converter_core.sv
rtl/p2pt_checker.sv
tb/packed_to_planar_tile_converter_core_tb.sv
